[src/lcdwcs_pkg.sv]
// Shared types and constants for the LCD window command sequencer.
`default_nettype none

package lcdwcs_pkg;

  // Input transaction: one update rectangle.
  typedef struct packed {
    logic [7:0] x_start;
    logic [7:0] y_start;
    logic [7:0] x_end;
    logic [7:0] y_end;
    logic       to_screen;
  } in_t;

  // Output transaction: one LCD port word.
  typedef struct packed {
    logic [31:0] port_word;
    logic        last_word;
  } out_t;

  // One queued port word: tag selects high (0x81) or low (0x80) prefix.
  typedef struct packed {
    logic       hi;
    logic [7:0] data;
  } word_t;

  localparam int unsigned MaxWords   = 14;
  localparam int unsigned Type0Words = 8;
  localparam int unsigned CntW       = $clog2(MaxWords + 1);

  // Register indexes.
  localparam logic [1:0] RegPanelType   = 2'd0;
  localparam logic [1:0] RegRotated     = 2'd1;
  localparam logic [1:0] RegScreenWidth = 2'd2;

  localparam logic [8:0] ScreenWidthRst = 9'd220;

  // Panel command codes.
  localparam logic [7:0] CmdXStart  = 8'h12;
  localparam logic [7:0] CmdYStart  = 8'h13;
  localparam logic [7:0] CmdXEnd    = 8'h15;
  localparam logic [7:0] CmdYEnd    = 8'h16;
  localparam logic [7:0] CmdHWindow = 8'h44;
  localparam logic [7:0] CmdVWindow = 8'h45;
  localparam logic [7:0] CmdCursor  = 8'h21;
  localparam logic [7:0] CmdDraw    = 8'h22;
  localparam logic [7:0] CmdPrefix  = 8'h00;

endpackage

`default_nettype wire

[src/lcd_window_command_sequencer_top.sv]
// Top level of the LCD window command sequencer.
`default_nettype none

// Takes one update rectangle per transaction and, when it targets the screen,
// emits the panel's window-setup port words, one word per cycle while
// out_stall_i is low: 8 words on a type 0 panel, 14 on a type 1 panel, with
// last_word set on the final one. Rectangles with to_screen clear are
// accepted and produce nothing. The accepted rectangle waits in an input
// register; the window arithmetic (even-width rounding, rotation with x
// mirrored about screen_width, ordering of ends on type 1) is one short
// combinational pass from that register into a 14-entry shift buffer that
// drives the output. The shift buffer sets the rate, and the words of the
// next rectangle follow the last word of the previous one with no gap.
// Configuration goes through an APB-style port (byte addresses 0, 4, 8) and
// must be written only while the block is idle.
module lcd_window_command_sequencer_top (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // rectangle input
  input  wire logic               in_valid_i,
  output      logic               in_stall_o,
  input  wire lcdwcs_pkg::in_t    in_data_i,
  // port word output
  output      logic               out_valid_o,
  input  wire logic               out_stall_i,
  output      lcdwcs_pkg::out_t   out_data_o,
  // configuration
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [3:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output      logic [31:0]        prdata,
  output      logic               pready
);

  localparam int unsigned NW = lcdwcs_pkg::MaxWords;
  localparam int unsigned CW = lcdwcs_pkg::CntW;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic       panel_type_q;
  logic       rotated_q;
  logic [8:0] screen_width_q;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      panel_type_q   <= 1'b0;
      rotated_q      <= 1'b0;
      screen_width_q <= lcdwcs_pkg::ScreenWidthRst;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        lcdwcs_pkg::RegPanelType:   panel_type_q   <= pwdata[0];
        lcdwcs_pkg::RegRotated:     rotated_q      <= pwdata[0];
        lcdwcs_pkg::RegScreenWidth: screen_width_q <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      lcdwcs_pkg::RegPanelType:   prdata = {31'd0, panel_type_q};
      lcdwcs_pkg::RegRotated:     prdata = {31'd0, rotated_q};
      lcdwcs_pkg::RegScreenWidth: prdata = {23'd0, screen_width_q};
      default:                    prdata = 32'd0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Input register
  // ---------------------------------------------------------------------------
  logic            in_vld_q, in_vld_d;
  lcdwcs_pkg::in_t in_q;
  logic            in_acc;
  logic            take;      // rectangle moves into the shift buffer
  logic [CW-1:0]   cnt_q, cnt_d;

  // Buffer free now, or its last word leaves this cycle.
  assign take       = in_vld_q &
                      ((cnt_q == '0) | ((cnt_q == CW'(1)) & ~out_stall_i));
  assign in_stall_o = in_vld_q & ~take;
  assign in_acc     = in_valid_i & ~in_stall_o;

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_acc)    in_vld_d = in_data_i.to_screen; // off-screen items are dropped
    else if (take) in_vld_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) in_vld_q <= 1'b0;
    else         in_vld_q <= in_vld_d;
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) in_q <= in_data_i;
  end

  // ---------------------------------------------------------------------------
  // Window arithmetic; 12-bit signed covers every reachable value
  // ---------------------------------------------------------------------------
  logic signed [11:0] sx, sy, mx, my, sw;
  logic signed [11:0] hgt, wid, wid_even;
  logic signed [11:0] r1, r2, r3, r4;
  logic signed [11:0] lo1, hi1, lo2, hi2, cur;
  lcdwcs_pkg::word_t  words [NW];
  logic [CW-1:0]      nwords;

  // High data byte of pack(hi, lo): hi byte ORed with lo's sign-extended bits 15:8.
  function automatic logic [7:0] pack_hi(logic signed [11:0] h, logic signed [11:0] l);
    return h[7:0] | {{4{l[11]}}, l[11:8]};
  endfunction

  always_comb begin
    sx  = {4'd0, in_q.x_start};
    sy  = {4'd0, in_q.y_start};
    mx  = {4'd0, in_q.x_end};
    my  = {4'd0, in_q.y_end};
    sw  = {3'd0, screen_width_q};
    hgt = my - sy + 12'sd1;
    wid = mx - sx + 12'sd1;
    wid_even = wid[0] ? wid + 12'sd1 : wid;

    if (!rotated_q) begin
      r1 = sx;
      r2 = sy;
      r3 = sx + wid_even - 12'sd1;
      r4 = sy + hgt - 12'sd1;
    end else begin
      r1 = sy;
      r2 = sw - 12'sd1 - sx;
      r3 = sy + hgt - 12'sd1;
      r4 = r2 - wid_even + 12'sd1;
    end

    lo1 = (r3 < r1) ? r3 : r1;
    hi1 = (r3 < r1) ? r1 : r3;
    lo2 = (r4 < r2) ? r4 : r2;
    hi2 = (r4 < r2) ? r2 : r4;
    cur = rotated_q ? hi2 : lo2;

    for (int i = 0; i < NW; i++) words[i] = '{hi: 1'b0, data: lcdwcs_pkg::CmdPrefix};

    if (!panel_type_q) begin
      nwords   = CW'(lcdwcs_pkg::Type0Words);
      words[0] = '{1'b0, lcdwcs_pkg::CmdXStart};
      words[1] = '{1'b0, r1[7:0]};
      words[2] = '{1'b0, lcdwcs_pkg::CmdYStart};
      words[3] = '{1'b0, r2[7:0]};
      words[4] = '{1'b0, lcdwcs_pkg::CmdXEnd};
      words[5] = '{1'b0, r3[7:0]};
      words[6] = '{1'b0, lcdwcs_pkg::CmdYEnd};
      words[7] = '{1'b0, r4[7:0]};
    end else begin
      nwords    = CW'(NW);
      words[0]  = '{1'b0, lcdwcs_pkg::CmdPrefix};
      words[1]  = '{1'b0, lcdwcs_pkg::CmdHWindow};
      words[2]  = '{1'b1, pack_hi(hi1, lo1)};
      words[3]  = '{1'b1, lo1[7:0]};
      words[4]  = '{1'b0, lcdwcs_pkg::CmdPrefix};
      words[5]  = '{1'b0, lcdwcs_pkg::CmdVWindow};
      words[6]  = '{1'b1, pack_hi(hi2, lo2)};
      words[7]  = '{1'b1, lo2[7:0]};
      words[8]  = '{1'b0, lcdwcs_pkg::CmdPrefix};
      words[9]  = '{1'b0, lcdwcs_pkg::CmdCursor};
      words[10] = '{1'b1, pack_hi(cur, lo1)};
      words[11] = '{1'b1, lo1[7:0]};
      words[12] = '{1'b0, lcdwcs_pkg::CmdPrefix};
      words[13] = '{1'b0, lcdwcs_pkg::CmdDraw};
    end
  end

  // ---------------------------------------------------------------------------
  // Output shift buffer: entry 0 is the word on the port
  // ---------------------------------------------------------------------------
  lcdwcs_pkg::word_t buf_q [NW];
  logic              out_fire;

  assign out_valid_o = (cnt_q != '0);
  assign out_fire    = out_valid_o & ~out_stall_i;

  always_comb begin
    cnt_d = cnt_q;
    if (take)          cnt_d = nwords;
    else if (out_fire) cnt_d = cnt_q - CW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cnt_q <= '0;
    else         cnt_q <= cnt_d;
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      for (int i = 0; i < NW; i++) buf_q[i] <= words[i];
    end else if (out_fire) begin
      for (int i = 0; i < NW - 1; i++) buf_q[i] <= buf_q[i+1];
    end
  end

  assign out_data_o.port_word = {7'b1000000, buf_q[0].hi, 16'd0, buf_q[0].data};
  assign out_data_o.last_word = (cnt_q == CW'(1));

endmodule

`default_nettype wire
